// ===== hdl/hbb_pkg.sv =====
`default_nettype none

package hbb_pkg;

  // Blur geometry.
  localparam int MAX_RADIUS = 16;
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int POS_CAP    = 2 * MAX_RADIUS + 2;

  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int SLOT_W = $clog2(WIN_DEPTH);
  localparam int POS_W  = $clog2(POS_CAP + 1);
  localparam int K_W    = POS_W + 1;
  localparam int SPAN_W = RAD_W + 1;

  // Pixel and channel widths.
  localparam int CH_W   = 8;
  localparam int NUM_CH = 4;
  localparam int PIX_W  = CH_W * NUM_CH;
  localparam int SUM_W  = $clog2(WIN_DEPTH * ((1 << CH_W) - 1) + 1);
  localparam int BIT_W  = $clog2(CH_W);

  // Channel positions inside a packed pixel word.
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;
  localparam int CH_ALPHA = 3;

  // Configuration space.
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int REG_IDX_W    = CFG_ADDR_W - 2;
  localparam int CFG_RADIUS_W = 5;
  localparam logic [REG_IDX_W-1:0]    REG_RADIUS   = '0;
  localparam logic [CFG_RADIUS_W-1:0] RADIUS_RESET = CFG_RADIUS_W'(8);

  // Command queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  n;
    logic [RAD_W-1:0]  r;
    logic [RAD_W-1:0]  c0;
    logic              emit;
    logic              row_end;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/hbb_front.sv =====
`default_nettype none

module hbb_front
  import hbb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [RAD_W-1:0] radius_eff,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [PIX_W-1:0] in_pix,
  input  wire logic             in_tlast,
  input  wire logic             q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [POS_W-1:0]  n_new;
  logic [SLOT_W-1:0] slot_new;
  logic              enough;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    // The first pixel of a row always lands in slot zero.
    if (pos_r == '0) begin
      slot_new = '0;
    end else if (slot_r == SLOT_W'(WIN_DEPTH - 1)) begin
      slot_new = '0;
    end else begin
      slot_new = slot_r + SLOT_W'(1);
    end
    n_new  = (pos_r < POS_W'(POS_CAP)) ? pos_r + POS_W'(1) : pos_r;
    enough = ((POS_W + 1)'(radius_eff) + (POS_W + 1)'(1)) <= (POS_W + 1)'(n_new);

    q_cmd.pix     = in_pix;
    q_cmd.slot    = slot_new;
    q_cmd.n       = n_new;
    q_cmd.r       = radius_eff;
    q_cmd.row_end = in_tlast;
    q_cmd.emit    = in_tlast || enough;
    q_cmd.c0      = (in_tlast && !enough) ? RAD_W'(n_new - POS_W'(1)) : radius_eff;

    pos_nxt  = pos_r;
    slot_nxt = slot_r;
    if (q_push) begin
      slot_nxt = slot_new;
      pos_nxt  = in_tlast ? '0 : n_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      slot_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hbb_queue.sv =====
`default_nettype none

module hbb_queue
  import hbb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      valid,
  input  wire logic pop,
  output cmd_t      pop_cmd
);

  cmd_t              entry_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full    = (cnt_r == QCNT_W'(Q_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hbb_back.sv =====
`default_nettype none

module hbb_back
  import hbb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  output logic                  q_pop,
  input  wire cmd_t             q_cmd,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [PIX_W-1:0]      out_pix,
  output logic                  out_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Window memory, one write and one registered read per cycle.
  logic [PIX_W-1:0]  win_mem [WIN_DEPTH];
  logic [PIX_W-1:0]  rd_data_r;
  logic              wr_en, rd_en;
  logic [SLOT_W-1:0] rd_idx;

  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [POS_W-1:0]             n_r, n_nxt;
  logic [RAD_W-1:0]             r_r, r_nxt;
  logic [RAD_W-1:0]             c_r, c_nxt;
  logic                         end_r, end_nxt;
  logic [K_W-1:0]               kk_r, kk_nxt;
  logic [SPAN_W-1:0]            left_r, left_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [NUM_CH-1:0][SUM_W-1:0] acc_r, acc_nxt;
  logic [NUM_CH-1:0][CH_W-1:0]  quo_r, quo_nxt;
  logic [BIT_W-1:0]             bit_r, bit_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]             out_pix_r, out_pix_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [SPAN_W-1:0] span;
  logic [K_W-1:0]    k_cl, k_diff;
  logic [SUM_W-1:0]  trial;
  logic              out_free;

  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign wr_en      = q_pop;
  assign rd_en      = (state_r == ST_READ);
  assign out_tvalid = out_valid_r;
  assign out_pix    = out_pix_r;
  assign out_tlast  = out_last_r;
  assign span       = {r_r, 1'b1};
  assign trial      = SUM_W'(span) << bit_r;
  assign out_free   = !out_valid_r || out_tready;

  // Clamp the backward distance to the pixels of this row, then map it to a slot.
  always_comb begin
    if (kk_r[K_W-1]) begin
      k_cl = '0;
    end else if (kk_r >= K_W'(n_r)) begin
      k_cl = K_W'(n_r) - K_W'(1);
    end else begin
      k_cl = kk_r;
    end
    k_diff = K_W'(slot_r) - k_cl;
    if (K_W'(slot_r) < k_cl) begin
      k_diff = k_diff + K_W'(WIN_DEPTH);
    end
    rd_idx = k_diff[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[q_cmd.slot] <= q_cmd.pix;
    end
    if (rd_en) begin
      rd_data_r <= win_mem[rd_idx];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    n_nxt         = n_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    end_nxt       = end_r;
    kk_nxt        = kk_r;
    left_nxt      = left_r;
    rd_vld_nxt    = 1'b0;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pix_nxt   = out_pix_r;
    out_last_nxt  = out_last_r;

    if (rd_vld_r) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        acc_nxt[ch] = acc_r[ch] + SUM_W'(rd_data_r[ch*CH_W +: CH_W]);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          slot_nxt = q_cmd.slot;
          n_nxt    = q_cmd.n;
          r_nxt    = q_cmd.r;
          c_nxt    = q_cmd.c0;
          end_nxt  = q_cmd.row_end;
          if (q_cmd.emit) begin
            kk_nxt    = K_W'(q_cmd.c0) + K_W'(q_cmd.r);
            left_nxt  = {q_cmd.r, 1'b1};
            acc_nxt   = '0;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_vld_nxt = 1'b1;
        kk_nxt     = kk_r - K_W'(1);
        left_nxt   = left_r - SPAN_W'(1);
        if (left_r == SPAN_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        quo_nxt   = '0;
        bit_nxt   = BIT_W'(CH_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // One quotient bit per cycle on all four channels.
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (acc_r[ch] >= trial) begin
            acc_nxt[ch]        = acc_r[ch] - trial;
            quo_nxt[ch][bit_r] = 1'b1;
          end
        end
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = quo_r;
          out_last_nxt  = end_r && (c_r == '0);
          if (end_r && (c_r != '0)) begin
            c_nxt     = c_r - RAD_W'(1);
            kk_nxt    = K_W'(c_r - RAD_W'(1)) + K_W'(r_r);
            left_nxt  = span;
            acc_nxt   = '0;
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
    slot_r     <= slot_nxt;
    n_r        <= n_nxt;
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    end_r      <= end_nxt;
    kk_r       <= kk_nxt;
    left_r     <= left_nxt;
    quo_r      <= quo_nxt;
    bit_r      <= bit_nxt;
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/horizontal_box_blur_row_core.sv =====
// Horizontal box blur for one image row of ARGB pixels. Each pixel beat on the
// input stream carries alpha, red, green and blue, and tlast marks the last
// pixel of a row. For every row position the block emits the truncated mean of
// the 2r+1 pixels centred on it, where r is the radius register (values above
// 16 act as 16); positions past either end of the row reuse the row's first or
// last pixel. Output lags input by r pixels, so a row shorter than r+1 pixels
// produces nothing until its tlast beat, and the tlast beat releases every
// remaining position of the row, the final one flagged with out_tlast. The
// front end takes a pixel in the cycle it arrives, unless the queue is full,
// and places it in a two-entry command queue, so up to two pixels can wait
// while the back end works. The back end computes each result from scratch:
// it takes the command and writes the pixel, makes 2r+1 window reads (one
// memory read port), finishes the sum, runs a restoring divider on all four
// channels and loads the output register; a further result released by a row
// end starts at the reads. New commands are taken only when idle. A pixel
// yielding no result is only written to the window. The radius must only be
// written while the block is idle; there is no clearing pass after reset.
`default_nettype none

module horizontal_box_blur_row_core
  import hbb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input pixel stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [PIX_W-1:0]      in_tdata,   // alpha, red, green, blue from bit 0 up
  input  wire logic                  in_tlast,   // row_end
  // Blurred pixel stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [PIX_W-1:0]           out_tdata,  // alpha_out, red_out, green_out, blue_out
  output logic                       out_tlast,  // row_last
  // Register port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  logic [CFG_RADIUS_W-1:0] radius_r;
  logic [RAD_W-1:0]        radius_eff;
  logic                    cfg_wr;
  logic [PIX_W-1:0]        in_pix;
  logic [PIX_W-1:0]        back_pix;

  cmd_t push_cmd, pop_cmd;
  logic q_push, q_full, q_valid, q_pop;

  // Register file: one register, the blur radius.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[CFG_ADDR_W-1:2] == REG_RADIUS);
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_RADIUS) ?
                      CFG_DATA_W'(radius_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr) begin
      radius_r <= cfg_pwdata[CFG_RADIUS_W-1:0];
    end
  end

  // Radius values beyond MAX_RADIUS saturate.
  assign radius_eff = (radius_r > CFG_RADIUS_W'(MAX_RADIUS)) ?
                      RAD_W'(MAX_RADIUS) : RAD_W'(radius_r);

  // The stream carries alpha in the low byte; internally alpha is the top byte.
  assign in_pix = {in_tdata[0 +: CH_W], in_tdata[CH_W +: CH_W],
                   in_tdata[2*CH_W +: CH_W], in_tdata[3*CH_W +: CH_W]};
  assign out_tdata = {back_pix[CH_BLUE*CH_W +: CH_W], back_pix[CH_GREEN*CH_W +: CH_W],
                      back_pix[CH_RED*CH_W +: CH_W], back_pix[CH_ALPHA*CH_W +: CH_W]};

  hbb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .radius_eff (radius_eff),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_pix     (in_pix),
    .in_tlast   (in_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  hbb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd)
  );

  hbb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (pop_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pix    (back_pix),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/hbb_checker.sv =====
`default_nettype none

module hbb_checker
  import hbb_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [PIX_W-1:0]      out_tdata,
  input wire logic                  out_tlast,
  input wire logic                  cfg_pready
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Reset empties the command queue, so a pixel can be taken at once.
  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("register port stalled");

endmodule

bind horizontal_box_blur_row_core hbb_checker u_hbb_checker (.*);

`default_nettype wire
